FILE: src/erg_pkg.sv
`default_nettype none

package erg_pkg;

  localparam int STEP_W     = 7;
  localparam int PULSE_W    = 7;
  localparam int ROT_W      = 6;
  localparam int POS_W      = 7;
  localparam int MAX_LEN    = 64;
  // (s-1)*r + p fits 13 bits, times n fits 20 bits
  localparam int SR_W       = 13;
  localparam int PROD_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_COUNT      = 2'd0,
    REG_PULSE_COUNT     = 2'd1,
    REG_ROTATION_AMOUNT = 2'd2
  } cfg_reg_e;

  // Control travelling down the modulo chain
  typedef struct packed {
    logic               valid;
    logic               zero;
    logic [STEP_W-1:0]  rem;
    logic [PROD_W-1:0]  dividend;
    logic [STEP_W-1:0]  steps;
    logic [PULSE_W-1:0] pulses;
  } cell_t;

endpackage

`default_nettype wire

FILE: src/euclidean_rhythm_generator.sv
`default_nettype none

// Euclidean rhythm generator. For each queried position the block returns whether a
// pulse sounds there, for a rhythm of step_count steps holding pulse_count pulses
// spread evenly and rotated forward by rotation_amount. Positions at or beyond
// step_count or 64 read 0, as does pulse_count 0. One query is taken per clock while
// in_stall_o is low. Two front stages form (p + (s-1)*r) * n, a chain of
// 20 cells reduces that product modulo s one bit per cell, and an output register
// holds the result. A two-entry output buffer lets the input keep flowing while a
// result waits. Registers are written through the configuration port, which is
// always ready; write them only while no query is in flight.
module euclidean_rhythm_generator import erg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [POS_W-1:0]      position_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       pulse_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [STEP_W-1:0]  step_count_q;
  logic [PULSE_W-1:0] pulse_count_q;
  logic [ROT_W-1:0]   rotation_amount_q;

  logic  en;
  cell_t chain [PROD_W+1];
  cell_t tail;
  logic  tail_pulse;

  logic  out_valid_q;
  logic  out_pulse_q;
  logic  skid_valid_q;
  logic  skid_pulse_q;
  logic  out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q      <= STEP_W'(16);
      pulse_count_q     <= PULSE_W'(4);
      rotation_amount_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_STEP_COUNT:      step_count_q      <= cfg_data_i[STEP_W-1:0];
        REG_PULSE_COUNT:     pulse_count_q     <= cfg_data_i[PULSE_W-1:0];
        REG_ROTATION_AMOUNT: rotation_amount_q <= cfg_data_i[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless the output buffer is full
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  erg_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .valid_i           (in_valid_i),
    .position_i        (position_i),
    .step_count_i      (step_count_q),
    .pulse_count_i     (pulse_count_q),
    .rotation_amount_i (rotation_amount_q),
    .head_o            (chain[0])
  );

  for (genvar g = 0; g < PROD_W; g++) begin : g_cell
    erg_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .prev_i (chain[g]),
      .next_o (chain[g+1])
    );
  end

  assign tail = chain[PROD_W];
  // Bresenham: a pulse lands where (i*n) mod s falls below n
  assign tail_pulse = !tail.zero && (tail.rem < tail.pulses);

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (tail.valid) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_pulse_q <= skid_pulse_q;
      end
    end else if (tail.valid) begin
      if (out_free) begin
        out_pulse_q <= tail_pulse;
      end else begin
        skid_pulse_q <= tail_pulse;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pulse_o     = out_pulse_q;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid buffer holds data while output register is empty");

  a_skid_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |=> !skid_valid_q)
    else $error("skid buffer filled although output register was free");

  a_skid_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_stall_i |=> skid_valid_q && $stable(skid_pulse_q))
    else $error("buffered result lost while output stalled");
`endif

endmodule

`default_nettype wire

FILE: src/erg_front.sv
`default_nettype none

module erg_front import erg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [POS_W-1:0]   position_i,
  input  wire logic [STEP_W-1:0]  step_count_i,
  input  wire logic [PULSE_W-1:0] pulse_count_i,
  input  wire logic [ROT_W-1:0]   rotation_amount_i,
  output cell_t                   head_o
);

  logic               a_valid_q;
  logic [POS_W-1:0]   a_pos_q;
  logic [STEP_W-1:0]  a_steps_q;
  logic [PULSE_W-1:0] a_pulses_q;
  logic               a_zero_q;
  logic [SR_W-1:0]    a_sr_q;

  logic [PULSE_W-1:0] pulses_eff;
  logic [STEP_W-1:0]  steps_m1;
  logic [SR_W-1:0]    sr_d;
  logic               zero_d;

  logic               b_valid_q;
  logic               b_zero_q;
  logic [PROD_W-1:0]  b_prod_q;
  logic [STEP_W-1:0]  b_steps_q;
  logic [PULSE_W-1:0] b_pulses_q;
  logic [SR_W-1:0]    sum;
  logic [PROD_W-1:0]  prod_d;

  assign pulses_eff = (pulse_count_i > step_count_i) ? step_count_i : pulse_count_i;
  assign steps_m1   = step_count_i - STEP_W'(1);
  // p - r is congruent to p + (s-1)*r modulo s, and never negative
  assign sr_d       = SR_W'(steps_m1) * SR_W'(rotation_amount_i);
  assign zero_d     = (step_count_i == '0) || (position_i >= step_count_i) ||
                      ({1'b0, position_i} >= (POS_W+1)'(MAX_LEN)) || (pulses_eff == '0);

  assign sum    = a_sr_q + SR_W'(a_pos_q);
  assign prod_d = PROD_W'(sum) * PROD_W'(a_pulses_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_pos_q    <= position_i;
      a_steps_q  <= step_count_i;
      a_pulses_q <= pulses_eff;
      a_zero_q   <= zero_d;
      a_sr_q     <= sr_d;
      b_zero_q   <= a_zero_q;
      b_prod_q   <= prod_d;
      b_steps_q  <= a_steps_q;
      b_pulses_q <= a_pulses_q;
    end
  end

  always_comb begin
    head_o          = '0;
    head_o.valid    = b_valid_q;
    head_o.zero     = b_zero_q;
    head_o.rem      = '0;
    head_o.dividend = b_prod_q;
    head_o.steps    = b_steps_q;
    head_o.pulses   = b_pulses_q;
  end

endmodule

`default_nettype wire

FILE: src/erg_cell.sv
`default_nettype none

// One restoring step of (i*n) mod s: shift in one dividend bit, subtract s if it fits.
module erg_cell import erg_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire cell_t prev_i,
  output cell_t      next_o
);

  logic              valid_q;
  cell_t             data_q;
  logic [STEP_W:0]   trial;
  logic [STEP_W:0]   reduced;
  cell_t             data_d;

  assign trial   = {prev_i.rem, prev_i.dividend[PROD_W-1]};
  assign reduced = (trial >= {1'b0, prev_i.steps}) ? (trial - {1'b0, prev_i.steps}) : trial;

  always_comb begin
    data_d          = prev_i;
    data_d.rem      = reduced[STEP_W-1:0];
    data_d.dividend = {prev_i.dividend[PROD_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    next_o       = data_q;
    next_o.valid = valid_q;
  end

endmodule

`default_nettype wire
